// File: design/fdc_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the feeder duty-cycle controller.
// No dependencies; every other file imports this package.
package fdc_pkg;

  // Event codes carried on the input channel.
  typedef enum logic [2:0] {
    OP_TICK   = 3'd0,
    OP_START  = 3'd1,
    OP_MANUAL = 3'd2,
    OP_ATTEN  = 3'd3,
    OP_EMERG  = 3'd4,
    OP_TRAY   = 3'd5
  } fdc_op_t;

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_AUTO_MODE = 2'd0,
    CFG_ON_SEC    = 2'd1,
    CFG_FIRST_SEC = 2'd2,
    CFG_OFF_SEC   = 2'd3
  } fdc_cfg_idx_t;

  localparam int SEC_W   = 16;
  localparam int CNT_W   = 32;
  // 65535 s expressed in ms still fits in 26 bits.
  localparam int LIMIT_W = 26;

  localparam logic [9:0]         MS_PER_SEC   = 10'd1000;
  localparam logic [LIMIT_W-1:0] MANUAL_ON_MS = LIMIT_W'(120000);

  localparam logic [LIMIT_W-1:0] RST_ON_MS    = LIMIT_W'(5 * 1000);
  localparam logic [LIMIT_W-1:0] RST_FIRST_MS = LIMIT_W'(10 * 1000);
  localparam logic [LIMIT_W-1:0] RST_OFF_MS   = LIMIT_W'(30 * 1000);

  // Configuration as seen by the control logic, period lengths already in ms.
  typedef struct packed {
    logic               auto_mode;
    logic [LIMIT_W-1:0] on_ms;
    logic [LIMIT_W-1:0] first_on_ms;
    logic [LIMIT_W-1:0] off_ms;
  } fdc_cfg_t;

  // Controller state presented to the output channel.
  typedef struct packed {
    logic             feeder_on;
    logic [CNT_W-1:0] start_count;
    logic [CNT_W-1:0] on_time_ms;
    logic             attenuated;
    logic             emergency_hold;
    logic             tray_opened;
  } fdc_status_t;

endpackage

// File: design/feeder_duty_cycle_controller.sv
`timescale 1ns / 1ps
// Feeder duty-cycle controller, top level: input register, control update, result register.
// An item is captured in the input register; its single-pass state update is registered.
// Throughput: one item per cycle while out_tready is high; a held result stalls the input.
// Reset (rst_n low, synchronous) clears the state and restores the default configuration.
// Depends on fdc_pkg, fdc_cfg and fdc_core.
module feeder_duty_cycle_controller import fdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  // Input: tuser[2:0] opcode; tdata[0] level, tdata[7:1] zero.
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,
  input  logic [2:0]       in_tuser,
  // Result: tdata[0] feeder_active, [32:1] start_total, [64:33] on_time_total_ms,
  // [65] blocked, [71:66] zero.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [71:0]      out_tdata,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SEC_W-1:0] cfg_data
);

  fdc_cfg_t    cfg;
  fdc_status_t status;

  logic       s1_valid_r;
  logic [2:0] s1_op_r;
  logic       s1_level_r;
  logic       out_valid_r;
  logic       step;

  // An item is processed once the result register is free or being emptied.
  assign step      = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || step;

  // Input register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s1_op_r    <= in_tuser;
      s1_level_r <= in_tdata[0];
    end
  end

  // Result valid; the payload is the state registers, which only move on a step.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  fdc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  fdc_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (step),
    .op     (s1_op_r),
    .level  (s1_level_r),
    .cfg    (cfg),
    .status (status)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0,
                       status.emergency_hold | status.tray_opened | status.attenuated,
                       status.on_time_ms,
                       status.start_count,
                       status.feeder_on};

  // The feeder is never on while the tray is open.
  a_tray_off: assert property (@(posedge clk) disable iff (!rst_n)
    status.tray_opened |-> !status.feeder_on)
    else $error("feeder on with tray open");

  // The start counter never goes backwards.
  a_starts_mono: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> status.start_count >= $past(status.start_count))
    else $error("start count decreased");

  // The state holds whenever no item is processed.
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !step |=> $stable(status))
    else $error("state changed without an item");

endmodule

// File: design/fdc_cfg.sv
`timescale 1ns / 1ps
// Configuration registers; period lengths are converted to milliseconds on write.
// Depends on fdc_pkg.
module fdc_cfg import fdc_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SEC_W-1:0] cfg_data,
  output fdc_cfg_t         cfg
);

  logic               auto_mode_r;
  logic [LIMIT_W-1:0] on_ms_r;
  logic [LIMIT_W-1:0] first_ms_r;
  logic [LIMIT_W-1:0] off_ms_r;
  logic [LIMIT_W-1:0] data_ms;
  logic               wr_en;

  // Writes are always taken.
  assign cfg_ready = 1'b1;
  assign wr_en     = cfg_valid;

  // Seconds to milliseconds: one 16 x 10 bit product, registered straight away.
  assign data_ms = LIMIT_W'(LIMIT_W'(cfg_data) * LIMIT_W'(MS_PER_SEC));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      auto_mode_r <= 1'b0;
      on_ms_r     <= RST_ON_MS;
      first_ms_r  <= RST_FIRST_MS;
      off_ms_r    <= RST_OFF_MS;
    end else if (wr_en) begin
      unique case (fdc_cfg_idx_t'(cfg_index))
        CFG_AUTO_MODE: auto_mode_r <= cfg_data[0];
        CFG_ON_SEC:    on_ms_r     <= data_ms;
        CFG_FIRST_SEC: first_ms_r  <= data_ms;
        CFG_OFF_SEC:   off_ms_r    <= data_ms;
        default: ;
      endcase
    end
  end

  assign cfg.auto_mode   = auto_mode_r;
  assign cfg.on_ms       = on_ms_r;
  assign cfg.first_on_ms = first_ms_r;
  assign cfg.off_ms      = off_ms_r;

endmodule

// File: design/fdc_core.sv
`timescale 1ns / 1ps
// Feeder control state and its single-pass update for one event.
// Depends on fdc_pkg.
module fdc_core import fdc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [2:0]  op,
  input  logic        level,
  input  fdc_cfg_t    cfg,
  output fdc_status_t status
);

  logic             feeder_on_r, feeder_on_nxt;
  logic             atten_r, atten_nxt;
  logic             after_att_r, after_att_nxt;
  logic             emerg_r, emerg_nxt;
  logic             tray_r, tray_nxt;
  logic [CNT_W-1:0] elapsed_r, elapsed_nxt;
  logic [CNT_W-1:0] on_time_r, on_time_nxt;
  logic [CNT_W-1:0] starts_r, starts_nxt;

  logic               [CNT_W-1:0] elapsed_inc;
  logic               [CNT_W-1:0] elapsed_base;
  logic               [CNT_W:0]   on_time_sum;
  logic               [CNT_W-1:0] starts_inc;
  logic               [LIMIT_W-1:0] limit;
  logic               has_limit;
  logic               expired;
  logic               req;
  logic               want;
  logic               want_eff;
  logic               do_switch;

  // Saturating increments and the on-time accumulation.
  assign elapsed_inc = (&elapsed_r) ? elapsed_r : elapsed_r + CNT_W'(1);
  assign starts_inc  = (&starts_r) ? starts_r : starts_r + CNT_W'(1);
  assign elapsed_base = (fdc_op_t'(op) == OP_TICK) ? elapsed_inc : elapsed_r;
  assign on_time_sum  = {1'b0, on_time_r} + {1'b0, elapsed_base};

  // Length of the running period and whether the tick ends it.
  always_comb begin
    has_limit = 1'b0;
    limit     = MANUAL_ON_MS;
    if (!emerg_r && !tray_r) begin
      if (cfg.auto_mode) begin
        has_limit = !atten_r;
        if (feeder_on_r) begin
          limit = after_att_r ? cfg.first_on_ms : cfg.on_ms;
        end else begin
          limit = cfg.off_ms;
        end
      end else begin
        has_limit = feeder_on_r;
      end
    end
  end

  assign expired = has_limit && !atten_r && (elapsed_inc >= CNT_W'(limit));

  // Event decode: switch request plus the flag updates of each event.
  always_comb begin
    req       = 1'b0;
    want      = 1'b0;
    atten_nxt = atten_r;
    emerg_nxt = emerg_r;
    tray_nxt  = tray_r;
    case (op)
      OP_TICK: begin
        req  = expired;
        want = !feeder_on_r;
      end
      OP_START: begin
        req  = 1'b1;
        want = 1'b1;
      end
      OP_MANUAL: begin
        req  = !cfg.auto_mode;
        want = level;
      end
      OP_ATTEN: begin
        if (cfg.auto_mode) begin
          req       = 1'b1;
          want      = !level;
          atten_nxt = level;
        end
      end
      OP_EMERG: begin
        req       = level;
        emerg_nxt = level;
      end
      OP_TRAY: begin
        req      = level;
        tray_nxt = level;
      end
      default: ;
    endcase
  end

  // An open tray turns any request to switch on into one to switch off.
  assign want_eff  = want && !tray_nxt;
  assign do_switch = req && (want_eff != feeder_on_r);

  always_comb begin
    feeder_on_nxt = feeder_on_r;
    after_att_nxt = after_att_r;
    elapsed_nxt   = elapsed_base;
    on_time_nxt   = on_time_r;
    starts_nxt    = starts_r;
    if (do_switch) begin
      feeder_on_nxt = want_eff;
      elapsed_nxt   = '0;
      if (feeder_on_r) begin
        on_time_nxt   = on_time_sum[CNT_W] ? {CNT_W{1'b1}} : on_time_sum[CNT_W-1:0];
        after_att_nxt = 1'b0;
      end else begin
        starts_nxt = starts_inc;
      end
    end
    // Attenuation switching on marks the next on period as the first one.
    if (fdc_op_t'(op) == OP_ATTEN && cfg.auto_mode && level) begin
      after_att_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      feeder_on_r <= 1'b0;
      atten_r     <= 1'b0;
      after_att_r <= 1'b0;
      emerg_r     <= 1'b0;
      tray_r      <= 1'b0;
      elapsed_r   <= '0;
      on_time_r   <= '0;
      starts_r    <= '0;
    end else if (step) begin
      feeder_on_r <= feeder_on_nxt;
      atten_r     <= atten_nxt;
      after_att_r <= after_att_nxt;
      emerg_r     <= emerg_nxt;
      tray_r      <= tray_nxt;
      elapsed_r   <= elapsed_nxt;
      on_time_r   <= on_time_nxt;
      starts_r    <= starts_nxt;
    end
  end

  assign status.feeder_on      = feeder_on_r;
  assign status.start_count    = starts_r;
  assign status.on_time_ms     = on_time_r;
  assign status.attenuated     = atten_r;
  assign status.emergency_hold = emerg_r;
  assign status.tray_opened    = tray_r;

endmodule
